### rtl/sfwh_pkg.sv
// ----------------------------------------------------------------------------
// sfwh_pkg
// shared constants, command codes and the control/status structs
// ----------------------------------------------------------------------------
package sfwh_pkg;

   localparam int STOP_WORDS_DEF  = 256;
   localparam int STOP_LEN_DEF    = 20;
   localparam int BUCKETS_DEF     = 10000;
   localparam int WORD_MAX_DEF    = 100;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int BUCKET_W = 14;
   localparam int LEN_W    = 7;
   localparam int OCOUNT_W = 16;

   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_COMMA  = 8'd44;
   localparam logic [7:0] CHAR_PERIOD = 8'd46;
   localparam logic [7:0] CHAR_LOWER  = 8'd96;
   localparam logic [7:0] CASE_DIFF   = 8'd32;

   typedef struct packed {
      logic take_char;    // latch input char
      logic char_step;    // apply text char to word state
      logic load_step;    // apply load char
      logic mod_start;
      logic mod_step;
      logic scan_start;
      logic scan_step;    // read or compare one char, advance
      logic rd_bucket;    // issue bucket read
      logic wr_bucket;    // write back and latch result
      logic word_clear;
   } sfwh_cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_sep;
      logic is_last;
      logic word_empty;
      logic mod_done;
      logic scan_done;
   } sfwh_sts_type;

endpackage

### rtl/sfwh_datapath.sv
// ----------------------------------------------------------------------------
// sfwh_datapath
// word state, stop table, hash reduction, stop scan and bucket counters
// ----------------------------------------------------------------------------
module sfwh_datapath
   import sfwh_pkg::*;
#(
   parameter int STOP_WORDS  = STOP_WORDS_DEF,
   parameter int STOP_LEN    = STOP_LEN_DEF,
   parameter int BUCKETS     = BUCKETS_DEF,
   parameter int WORD_MAX    = WORD_MAX_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfwh_cmd_type            cmd,
   output sfwh_sts_type            sts,
   output logic                    clr_busy,
   input  logic                    req_command,
   input  logic [7:0]              req_char_code,
   input  logic                    req_last,
   output logic [BUCKET_W-1:0]     rsp_bucket,
   output logic                    rsp_is_stop,
   output logic [OCOUNT_W-1:0]     rsp_bucket_count,
   output logic [OCOUNT_W-1:0]     rsp_max_count,
   output logic [LEN_W-1:0]        rsp_word_length
);

   localparam int SW_W  = $clog2(STOP_WORDS + 1);
   localparam int SI_W  = (STOP_WORDS > 1) ? $clog2(STOP_WORDS) : 1;
   localparam int SA_W  = $clog2(STOP_WORDS * STOP_LEN);
   localparam int PL_W  = $clog2(STOP_LEN + 1);
   localparam int PI_W  = $clog2(STOP_LEN);
   localparam int WC_W  = $clog2(WORD_MAX + 1);
   localparam int B_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int HS_W  = 32;
   localparam int MD_W  = B_W + 1;
   // largest hash magnitude: letter value at most 158, weights sum to n(n+1)/2
   localparam longint HASH_MAX = longint'(158) * WORD_MAX * (WORD_MAX + 1) / 2;
   localparam int HM_W  = $clog2(HASH_MAX + 1);
   localparam int RS    = HM_W + B_W;
   localparam int RC_W  = HM_W + 1;
   localparam int PR_W  = HM_W + RC_W;
   localparam int QT_W  = PR_W - RS;
   localparam int RM_W  = HM_W + 1;
   localparam int QB_W  = HM_W + 2;
   localparam logic [COUNT_WIDTH-1:0] LIMIT = '1;
   localparam logic [MD_W-1:0] BUCKETS_V = MD_W'(BUCKETS);
   localparam logic [RC_W-1:0] RECIP_V = RC_W'((longint'(1) << RS) / BUCKETS);

   localparam logic [1:0] MPH_MUL = 2'd0;
   localparam logic [1:0] MPH_SUB = 2'd1;
   localparam logic [1:0] MPH_FIX = 2'd2;

   // input latch
   logic       cmd_ff;
   logic [7:0] ch_ff;
   logic       last_ff;

   // word state
   logic [WC_W-1:0]       chars_ff;
   logic signed [HS_W-1:0] hash_ff;
   logic [7:0]            prefix_ff [STOP_LEN];

   // stop table
   logic [7:0]      stop_mem [STOP_WORDS * STOP_LEN];
   logic [PL_W-1:0] len_mem  [STOP_WORDS];
   logic [SW_W-1:0] stop_count_ff;
   logic [PL_W-1:0] load_pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_char) begin
         cmd_ff  <= req_command;
         ch_ff   <= req_char_code;
         last_ff <= req_last;
      end
   end

   logic sep;
   assign sep = (ch_ff == CHAR_SPACE) || (ch_ff == CHAR_COMMA) || (ch_ff == CHAR_PERIOD);

   assign sts.is_load    = cmd_ff == CMD_LOAD;
   assign sts.is_sep     = sep;
   assign sts.is_last    = last_ff;
   assign sts.word_empty = chars_ff == '0;

   // letter value times position
   logic signed [8:0]      letter_v;
   logic [WC_W-1:0]        pos_n;
   logic signed [HS_W-1:0] prod;
   assign letter_v = (ch_ff > CHAR_LOWER) ? ($signed({1'b0, ch_ff}) - 9'sd97)
                                          : ($signed({1'b0, ch_ff}) - 9'sd65);
   assign pos_n = chars_ff + WC_W'(1);
   assign prod  = HS_W'(letter_v) * $signed({1'b0, pos_n});

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
         hash_ff  <= '0;
      end else if (cmd.word_clear) begin
         chars_ff <= '0;
         hash_ff  <= '0;
      end else if (cmd.char_step && !sep && (chars_ff < WC_W'(WORD_MAX))) begin
         chars_ff <= pos_n;
         hash_ff  <= hash_ff + prod;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.char_step && !sep && (chars_ff < WC_W'(STOP_LEN)))
         prefix_ff[chars_ff[PI_W-1:0]] <= ch_ff;
   end

   // stop-word load
   logic [SI_W-1:0] wr_word;
   assign wr_word = stop_count_ff[SI_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         load_pos_ff   <= '0;
      end else if (cmd.load_step) begin
         if (stop_count_ff < SW_W'(STOP_WORDS)) begin
            if (last_ff)
               stop_count_ff <= stop_count_ff + SW_W'(1);
            if (load_pos_ff < PL_W'(STOP_LEN))
               load_pos_ff <= load_pos_ff + PL_W'(1);
         end
         if (last_ff)
            load_pos_ff <= '0;
      end
   end

   logic [PL_W-1:0] new_len;
   assign new_len = (load_pos_ff < PL_W'(STOP_LEN)) ? load_pos_ff + PL_W'(1) : load_pos_ff;

   // scan read address
   logic [SI_W-1:0] scan_word_ff;
   logic [PL_W-1:0] scan_pos_ff;
   logic [7:0]      rd_char_ff;
   logic [PL_W-1:0] rd_len_ff;
   logic [SA_W-1:0] wr_addr;
   logic [SA_W-1:0] rd_addr;

   assign wr_addr = SA_W'(wr_word) * SA_W'(STOP_LEN) + SA_W'(load_pos_ff[PI_W-1:0]);
   assign rd_addr = SA_W'(scan_word_ff) * SA_W'(STOP_LEN) + SA_W'(scan_pos_ff[PI_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.load_step && stop_count_ff < SW_W'(STOP_WORDS)) begin
         if (load_pos_ff < PL_W'(STOP_LEN))
            stop_mem[wr_addr] <= ch_ff;
         if (last_ff)
            len_mem[wr_word] <= new_len;
      end
      rd_char_ff <= stop_mem[rd_addr];
      rd_len_ff  <= len_mem[scan_word_ff];
   end

   // modulo: reciprocal multiply, subtract, one correction step
   logic              neg_ff;
   logic [HM_W-1:0]   mag_ff;
   logic [PR_W-1:0]   prod_ff;
   logic [RM_W-1:0]   rem_ff;
   logic [1:0]        mph_ff;
   logic [B_W-1:0]    bucket_ff;
   logic              mdone_ff;
   logic [QT_W-1:0]   qt;
   logic [QB_W-1:0]   qb;
   logic [RM_W-1:0]   rfix;

   assign qt   = prod_ff[PR_W-1:RS];
   assign qb   = QB_W'(qt) * QB_W'(BUCKETS_V);
   assign rfix = (rem_ff >= RM_W'(BUCKETS)) ? rem_ff - RM_W'(BUCKETS) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mdone_ff <= 1'b0;
         mph_ff   <= MPH_MUL;
      end else if (cmd.mod_start) begin
         neg_ff   <= hash_ff[HS_W-1];
         mag_ff   <= HM_W'(hash_ff[HS_W-1] ? -hash_ff : hash_ff);
         mph_ff   <= MPH_MUL;
         mdone_ff <= 1'b0;
      end else if (cmd.mod_step && !mdone_ff) begin
         unique case (mph_ff)
            MPH_MUL: begin
               prod_ff <= PR_W'(mag_ff) * PR_W'(RECIP_V);
               mph_ff  <= MPH_SUB;
            end
            MPH_SUB: begin
               rem_ff <= RM_W'(QB_W'(mag_ff) - qb);
               mph_ff <= MPH_FIX;
            end
            default: begin
               mdone_ff <= 1'b1;
               if (neg_ff && rfix != '0)
                  bucket_ff <= B_W'(RM_W'(BUCKETS) - rfix);
               else
                  bucket_ff <= B_W'(rfix);
            end
         endcase
      end
   end
   assign sts.mod_done = mdone_ff;

   // stop scan: one char at a time, registered read (addr -> data next cycle), then compare
   logic            pend_ff;   // read data valid for previous address
   logic [SI_W-1:0] pw_ff;
   logic [PL_W-1:0] pp_ff;
   logic            match_ff;
   logic            sdone_ff;
   logic            char_ok;
   logic [7:0]      wch;
   logic            last_word;

   assign wch = prefix_ff[pp_ff[PI_W-1:0]];
   assign char_ok = (pp_ff == '0)
      ? ((rd_char_ff == wch) || (({1'b0, rd_char_ff} - {1'b0, CASE_DIFF}) == {1'b0, wch}))
      : (rd_char_ff == wch);
   assign last_word = (SW_W'(pw_ff) + SW_W'(1)) >= stop_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sdone_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_word_ff <= '0;
         scan_pos_ff  <= '0;
         match_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         sdone_ff     <= (chars_ff > WC_W'(STOP_LEN)) || (stop_count_ff == '0);
      end else if (cmd.scan_step && !sdone_ff) begin
         if (!pend_ff) begin
            pend_ff <= 1'b1;
            pw_ff   <= scan_word_ff;
            pp_ff   <= scan_pos_ff;
         end else begin
            pend_ff <= 1'b0;
            if (WC_W'(rd_len_ff) != chars_ff || !char_ok) begin
               if (last_word) sdone_ff <= 1'b1;
               else begin
                  scan_word_ff <= pw_ff + SI_W'(1);
                  scan_pos_ff  <= '0;
               end
            end else if (WC_W'(pp_ff) + WC_W'(1) == chars_ff) begin
               match_ff <= 1'b1;
               sdone_ff <= 1'b1;
            end else begin
               scan_pos_ff <= pp_ff + PL_W'(1);
            end
         end
      end
   end
   assign sts.scan_done = sdone_ff;

   // bucket counters with clear pass
   logic [COUNT_WIDTH-1:0] cnt_mem [BUCKETS];
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [COUNT_WIDTH-1:0] max_ff;
   logic [COUNT_WIDTH-1:0] cnt_new;
   assign cnt_new = match_ff ? cnt_rd_ff
                  : ((cnt_rd_ff < LIMIT) ? cnt_rd_ff + COUNT_WIDTH'(1) : cnt_rd_ff);

   logic            clr_on_ff;
   logic [B_W-1:0]  clr_addr_ff;
   assign clr_busy = clr_on_ff;

   always_ff @(posedge clock) begin
      if (clr_on_ff)
         cnt_mem[clr_addr_ff] <= '0;
      else if (cmd.wr_bucket && !match_ff)
         cnt_mem[bucket_ff] <= cnt_new;
      if (cmd.rd_bucket)
         cnt_rd_ff <= cnt_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_on_ff   <= 1'b1;
         clr_addr_ff <= '0;
         max_ff      <= '0;
      end else begin
         if (clr_on_ff) begin
            if (clr_addr_ff == B_W'(BUCKETS - 1)) clr_on_ff <= 1'b0;
            else clr_addr_ff <= clr_addr_ff + B_W'(1);
         end
         if (cmd.wr_bucket && !match_ff && cnt_new > max_ff)
            max_ff <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_bucket) begin
         rsp_bucket       <= BUCKET_W'(bucket_ff);
         rsp_is_stop      <= match_ff;
         rsp_bucket_count <= OCOUNT_W'(cnt_new);
         rsp_max_count    <= OCOUNT_W'((!match_ff && cnt_new > max_ff) ? cnt_new : max_ff);
         rsp_word_length  <= LEN_W'(chars_ff);
      end
   end

endmodule

### rtl/sfwh_control.sv
// ----------------------------------------------------------------------------
// sfwh_control
// sequencer: takes each char, applies loads, drives hash reduction, stop scan and bucket update
// ----------------------------------------------------------------------------
module sfwh_control
   import sfwh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         clr_busy,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  sfwh_sts_type sts,
   output sfwh_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHAR = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       finish;

   assign req_ready = (state_ff == S_IDLE) && !clr_busy && !rv_ff;
   assign rsp_valid = rv_ff;
   assign finish = sts.is_sep || sts.is_last;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      rv_in    = rv_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take_char = 1'b1;
               state_in = S_CHAR;
            end
         end
         S_CHAR: begin
            if (sts.is_load) begin
               cmd.load_step = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.char_step = 1'b1;
               state_in = finish ? S_MOD : S_IDLE;
            end
         end
         S_MOD: begin
            if (sts.word_empty) begin
               cmd.word_clear = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.mod_start  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.mod_step  = 1'b1;
            cmd.scan_step = 1'b1;
            if (sts.mod_done && sts.scan_done) state_in = S_RD;
         end
         S_RD: begin
            cmd.rd_bucket = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.wr_bucket = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.word_clear = 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

### rtl/stop_filtered_word_hash_counter_unit.sv
// ----------------------------------------------------------------------------
// stop_filtered_word_hash_counter_unit
// Text and stop-word characters arrive one per transfer on req_. After a
// character is accepted, req_ready stays low while S_CHAR applies it. A
// finished word then passes through a setup state (S_MOD), the hash
// reduction in parallel with the stop-table walk (a read, then a compare,
// per letter), then the counter update (S_RD, S_WR, S_OUT) before
// rsp_ shows it. After reset the counter memory is cleared bucket by bucket,
// and no word is taken until that pass ends. Only one word is in
// flight at a time, and no new word is taken while a result waits on rsp_.
// ----------------------------------------------------------------------------
module stop_filtered_word_hash_counter_unit
   import sfwh_pkg::*;
#(
   parameter int STOP_WORDS  = STOP_WORDS_DEF,
   parameter int STOP_LEN    = STOP_LEN_DEF,
   parameter int BUCKETS     = BUCKETS_DEF,
   parameter int WORD_MAX    = WORD_MAX_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_char_code,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BUCKET_W-1:0] rsp_bucket,
   output logic                rsp_is_stop,
   output logic [OCOUNT_W-1:0] rsp_bucket_count,
   output logic [OCOUNT_W-1:0] rsp_max_count,
   output logic [LEN_W-1:0]    rsp_word_length
);

   sfwh_cmd_type cmd;
   sfwh_sts_type sts;
   logic         clr_busy;

   sfwh_control u_ctl (
      .clock, .reset, .clr_busy, .req_valid, .req_ready,
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   sfwh_datapath #(
      .STOP_WORDS(STOP_WORDS), .STOP_LEN(STOP_LEN), .BUCKETS(BUCKETS),
      .WORD_MAX(WORD_MAX), .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .clr_busy, .req_command, .req_char_code, .req_last,
      .rsp_bucket, .rsp_is_stop, .rsp_bucket_count, .rsp_max_count, .rsp_word_length
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text and stop-word characters into the word hash counter, predicts
// each finished word's bucket, stop flag, counts and length, and compares
// every result word with the oldest prediction. Covers separators, empty
// tokens, case-folded first letters, long words, long stop words and a full
// stop table, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import sfwh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic       command;
      logic [7:0] char_code;
      logic       last;
   } char_item_type;

   typedef struct {
      logic [BUCKET_W-1:0] bucket;
      logic                is_stop;
      logic [OCOUNT_W-1:0] bucket_count;
      logic [OCOUNT_W-1:0] max_count;
      logic [LEN_W-1:0]    word_length;
   } word_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = 1'b0;
   logic [7:0]          req_char_code = 8'd0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BUCKET_W-1:0] rsp_bucket;
   logic                rsp_is_stop;
   logic [OCOUNT_W-1:0] rsp_bucket_count;
   logic [OCOUNT_W-1:0] rsp_max_count;
   logic [LEN_W-1:0]    rsp_word_length;

   stop_filtered_word_hash_counter_unit i_dut (.*);

   always #2 clock = ~clock;

   char_item_type   pending_chars[$];
   word_result_type expected_words[$];
   int              items_taken = 0;
   logic            calm;
   int              mismatches = 0;

   // no idling while this stretch of characters is taken
   assign calm = (items_taken > 60) && (items_taken < 200);

   // predictor state
   logic [7:0]  stop_tab[STOP_WORDS_DEF][STOP_LEN_DEF];
   int          stop_tab_len[STOP_WORDS_DEF];
   int          stop_tab_n = 0;
   int          load_pos = 0;
   logic [7:0]  word_head[STOP_LEN_DEF];
   int          word_len = 0;
   longint      hash_acc = 0;
   int          bucket_tally[BUCKETS_DEF];
   int          tally_max = 0;

   // stimulus bookkeeping: stop words that can be echoed in text
   logic [7:0]  known_sw[STOP_WORDS_DEF][STOP_LEN_DEF];
   int          known_sw_len[STOP_WORDS_DEF];
   int          known_n = 0;
   int          loads_done = 0;
   int          items_sent = 0;

   initial foreach (bucket_tally[i]) bucket_tally[i] = 0;

   task automatic hash_and_count(input logic cmd, input logic [7:0] c, input logic lst);
      int              v, r, i, j, cnt;
      bit              sep, hit;
      word_result_type w;
      if (cmd == CMD_LOAD) begin
         if (stop_tab_n < STOP_WORDS_DEF) begin
            if (load_pos < STOP_LEN_DEF) begin
               stop_tab[stop_tab_n][load_pos] = c;
               load_pos++;
            end
            if (lst) begin
               stop_tab_len[stop_tab_n] = load_pos;
               stop_tab_n++;
            end
         end
         if (lst) load_pos = 0;
         return;
      end
      sep = (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_PERIOD);
      if (!sep) begin
         if (word_len < WORD_MAX_DEF) begin
            v = (c > CHAR_LOWER) ? int'(c) - 97 : int'(c) - 65;
            if (word_len < STOP_LEN_DEF) word_head[word_len] = c;
            word_len++;
            hash_acc += longint'(v) * word_len;
         end
         if (!lst) return;
      end
      if (word_len == 0) begin
         hash_acc = 0;
         return;
      end
      r = int'(hash_acc % BUCKETS_DEF);
      if (r < 0) r += BUCKETS_DEF;
      hit = 1'b0;
      if (word_len <= STOP_LEN_DEF) begin
         for (i = 0; i < stop_tab_n && !hit; i++) begin
            if (stop_tab_len[i] != word_len) continue;
            if (!(int'(stop_tab[i][0]) == int'(word_head[0]) ||
                  int'(stop_tab[i][0]) - 32 == int'(word_head[0]))) continue;
            for (j = 1; j < word_len; j++)
               if (word_head[j] != stop_tab[i][j]) break;
            if (j == word_len) hit = 1'b1;
         end
      end
      cnt = bucket_tally[r];
      if (!hit) begin
         if (cnt < (1 << COUNT_WIDTH_DEF) - 1) cnt++;
         bucket_tally[r] = cnt;
         if (cnt > tally_max) tally_max = cnt;
      end
      w.bucket       = r[BUCKET_W-1:0];
      w.is_stop      = hit;
      w.bucket_count = cnt[OCOUNT_W-1:0];
      w.max_count    = tally_max[OCOUNT_W-1:0];
      w.word_length  = word_len[LEN_W-1:0];
      expected_words.push_back(w);
      word_len = 0;
      hash_acc = 0;
   endtask

   // driver
   always @(posedge clock) begin
      char_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            hash_and_count(req_command, req_char_code, req_last);
            items_taken++;
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
               it = pending_chars.pop_front();
               req_valid     <= 1'b1;
               req_command   <= it.command;
               req_char_code <= it.char_code;
               req_last      <= it.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      word_result_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word result: bucket %0d", rsp_bucket);
            end else begin
               w = expected_words.pop_front();
               if (rsp_bucket !== w.bucket || rsp_is_stop !== w.is_stop ||
                   rsp_bucket_count !== w.bucket_count || rsp_max_count !== w.max_count ||
                   rsp_word_length !== w.word_length) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                              w.bucket, w.is_stop, w.bucket_count, w.max_count, w.word_length,
                              rsp_bucket, rsp_is_stop, rsp_bucket_count, rsp_max_count,
                              rsp_word_length);
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   task automatic send(input logic cmd, input logic [7:0] c, input logic lst);
      char_item_type it;
      it.command = cmd;
      it.char_code = c;
      it.last = lst;
      pending_chars.push_back(it);
      items_sent++;
   endtask

   function automatic logic [7:0] any_letter();
      int r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (r < 70) return 8'($urandom_range(122, 97));
      if (r < 85) return 8'($urandom_range(90, 65));
      do c = 8'($urandom_range(255)); while (c == CHAR_SPACE || c == CHAR_COMMA || c == CHAR_PERIOD);
      return c;
   endfunction

   function automatic logic [7:0] any_sep();
      case ($urandom_range(2))
         0: return CHAR_SPACE;
         1: return CHAR_COMMA;
         default: return CHAR_PERIOD;
      endcase
   endfunction

   task automatic load_stop_word(input int n);
      int i;
      logic [7:0] c;
      for (i = 0; i < n; i++) begin
         c = ($urandom_range(9) == 0) ? any_letter() : 8'($urandom_range(122, 97));
         if (known_n < STOP_WORDS_DEF && i < STOP_LEN_DEF) known_sw[known_n][i] = c;
         send(CMD_LOAD, c, i == n - 1);
      end
      if (known_n < STOP_WORDS_DEF) begin
         known_sw_len[known_n] = (n > STOP_LEN_DEF) ? STOP_LEN_DEF : n;
         known_n++;
      end
      loads_done++;
   endtask

   task automatic say_word(input logic lst);
      int n, i, k, r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (known_n > 0 && r < 40) begin
         k = $urandom_range(known_n - 1);
         for (i = 0; i < known_sw_len[k]; i++) begin
            c = known_sw[k][i];
            if (i == 0 && c >= 97 && c <= 122 && $urandom_range(1)) c = c - CASE_DIFF;
            send(CMD_TEXT, c, lst && i == known_sw_len[k] - 1);
         end
         return;
      end
      if (r < 94)      n = $urandom_range(8, 1);
      else if (r < 98) n = $urandom_range(22, 9);
      else             n = $urandom_range(110, 90);
      for (i = 0; i < n; i++) send(CMD_TEXT, any_letter(), lst && i == n - 1);
   endtask

   task automatic say_sentence();
      int nw, i;
      bit sep_end;
      nw = $urandom_range(5, 1);
      sep_end = $urandom_range(1);
      for (i = 0; i < nw; i++) begin
         if (i == nw - 1 && !sep_end) begin
            say_word(1'b1);
         end else begin
            say_word(1'b0);
            if (i == nw - 1) send(CMD_TEXT, any_sep(), 1'b1);
            else begin
               send(CMD_TEXT, any_sep(), 1'b0);
               if ($urandom_range(9) == 0) send(CMD_TEXT, any_sep(), 1'b0);
            end
         end
      end
   endtask

   task automatic drain();
      while (pending_chars.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: stop words, case fold, empty tokens, negative hash, high bytes
      send(CMD_LOAD, "a", 1'b0); send(CMD_LOAD, "b", 1'b1);
      send(CMD_LOAD, "x", 1'b1);
      send(CMD_TEXT, "A", 1'b0); send(CMD_TEXT, "b", 1'b0); send(CMD_TEXT, CHAR_SPACE, 1'b0);
      send(CMD_TEXT, "a", 1'b0); send(CMD_TEXT, "b", 1'b0); send(CMD_TEXT, CHAR_COMMA, 1'b0);
      send(CMD_TEXT, CHAR_COMMA, 1'b0); send(CMD_TEXT, CHAR_PERIOD, 1'b0);
      send(CMD_TEXT, "x", 1'b0); send(CMD_TEXT, CHAR_PERIOD, 1'b0);
      send(CMD_TEXT, "0", 1'b0); send(CMD_TEXT, 8'd0, 1'b0); send(CMD_TEXT, CHAR_SPACE, 1'b0);
      send(CMD_TEXT, 8'hff, 1'b0); send(CMD_TEXT, CHAR_PERIOD, 1'b1);
      send(CMD_TEXT, CHAR_SPACE, 1'b1);
      send(CMD_TEXT, "q", 1'b1);
      send(CMD_TEXT, "B", 1'b0); send(CMD_TEXT, "b", 1'b1);
      drain();

      // random text over a small stop table, with a calm stretch
      while (items_sent < 200) begin
         if (loads_done < 30 && $urandom_range(9) < 2)
            load_stop_word(($urandom_range(19) == 0) ? $urandom_range(26, 21)
                                                     : $urandom_range(6, 1));
         else if ($urandom_range(19) == 0)
            send(CMD_TEXT, any_sep(), $urandom_range(1));
         else
            say_sentence();
         if (items_sent > 120 && items_sent < 140) drain();
      end
      drain();

      // fill the stop table past its capacity, then text against it
      while (loads_done < STOP_WORDS_DEF + 4) load_stop_word($urandom_range(3, 1));
      repeat (8) say_sentence();
      drain();
      repeat (11000) @(posedge clock);

      if (mismatches == 0 && expected_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### stop_filtered_word_hash_counter_unit.f
rtl/sfwh_pkg.sv
rtl/sfwh_datapath.sv
rtl/sfwh_control.sv
rtl/stop_filtered_word_hash_counter_unit.sv
tb/testbench.sv
